### src/range_max_tree_defines.svh
// Assertion macros shared by the block
`ifndef RANGE_MAX_TREE_DEFINES_SVH
`define RANGE_MAX_TREE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define RMT_ASSERT_IMPL(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define RMT_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### src/rmt_pkg.sv
package rmt_pkg;

	localparam int LEAVES     = 1024;
	localparam int VALUE_BITS = 20;
	localparam int FIELD_BITS = 20;
	localparam int SIZE_BITS  = 11;
	localparam int DEPTH      = 2 * LEAVES;
	localparam int NODE_BITS  = $clog2(DEPTH);
	localparam int WALK_BITS  = NODE_BITS + 1;
	localparam int SIZE_MAX   = (1 << SIZE_BITS) - 1;
	localparam int SIZE_RESET = (LEAVES > SIZE_MAX) ? SIZE_MAX : LEAVES;

	localparam int IN_DATA_BITS  = ((3 * SIZE_BITS + FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((2 * FIELD_BITS + 1 + 7) / 8) * 8;

	typedef logic [VALUE_BITS-1:0]    value_t;
	typedef logic [FIELD_BITS-1:0]    field_t;
	typedef logic [SIZE_BITS-1:0]     size_t;
	typedef logic [NODE_BITS-1:0]     node_t;
	typedef logic [WALK_BITS-1:0]     walk_t;
	typedef logic [IN_DATA_BITS-1:0]  in_data_t;
	typedef logic [OUT_DATA_BITS-1:0] out_data_t;

	typedef struct packed {
		logic   action;
		size_t  position;
		field_t value;
		size_t  range_low;
		size_t  range_high;
	} item_t;

	typedef struct packed {
		logic start;
		logic ack;
	} seq_ctl_t;

	typedef struct packed {
		logic   ready;
		logic   done;
		value_t range_max;
		value_t overall_max;
		logic   bad;
	} seq_sts_t;

	typedef struct packed {
		logic   we;
		node_t  waddr;
		value_t wdata;
		node_t  raddr;
	} ram_req_t;

	function automatic size_t eff_size(size_t used);
		if (int'(used) > LEAVES) begin
			return size_t'(LEAVES);
		end
		return used;
	endfunction

	function automatic value_t vmax(value_t a, value_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

### src/rmt_ram.sv
module rmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/rmt_seq.sv
module rmt_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  rmt_pkg::size_t    size,
	input  rmt_pkg::seq_ctl_t ctl,
	input  rmt_pkg::item_t    item,
	output rmt_pkg::seq_sts_t sts,
	output rmt_pkg::ram_req_t ram,
	input  rmt_pkg::value_t   rdata
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_WLEAF = 3'd2;
	localparam logic [2:0] S_WUP   = 3'd3;
	localparam logic [2:0] S_QL    = 3'd4;
	localparam logic [2:0] S_QR    = 3'd5;
	localparam logic [2:0] S_OVR   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]      state_q;
	rmt_pkg::node_t  clr_q;
	rmt_pkg::walk_t  left_q;
	rmt_pkg::walk_t  right_q;
	rmt_pkg::node_t  node_q;
	rmt_pkg::value_t cur_q;
	rmt_pkg::value_t best_q;
	logic            pend_q;
	logic            phase_q;
	rmt_pkg::value_t rmax_q;
	rmt_pkg::value_t ovr_q;
	logic            bad_q;

	rmt_pkg::size_t  lo_c;
	rmt_pkg::size_t  hi_c;
	logic            q_empty;
	rmt_pkg::walk_t  q_left;
	rmt_pkg::walk_t  q_right;
	logic            pos_ok;
	rmt_pkg::node_t  leaf;
	rmt_pkg::walk_t  ov_right;
	rmt_pkg::walk_t  right_m1;
	rmt_pkg::value_t best_next;
	rmt_pkg::node_t  parent;
	rmt_pkg::value_t up_val;
	logic            walk_go;

	assign lo_c     = (item.range_low == '0) ? rmt_pkg::size_t'(1) : item.range_low;
	assign hi_c     = (item.range_high > size) ? size : item.range_high;
	assign q_empty  = lo_c > hi_c;
	assign q_left   = rmt_pkg::walk_t'(rmt_pkg::LEAVES) + rmt_pkg::walk_t'(lo_c)
		- rmt_pkg::walk_t'(1);
	assign q_right  = rmt_pkg::walk_t'(rmt_pkg::LEAVES) + rmt_pkg::walk_t'(hi_c);
	assign pos_ok   = (item.position != '0) && (item.position <= size);
	assign leaf     = rmt_pkg::node_t'(rmt_pkg::LEAVES) + rmt_pkg::node_t'(item.position)
		- rmt_pkg::node_t'(1);
	assign ov_right = rmt_pkg::walk_t'(rmt_pkg::LEAVES) + rmt_pkg::walk_t'(size);
	assign right_m1 = right_q - rmt_pkg::walk_t'(1);
	assign best_next = (pend_q && (rdata > best_q)) ? rdata : best_q;
	assign parent   = node_q >> 1;
	assign up_val   = rmt_pkg::vmax(cur_q, rdata);
	assign walk_go  = left_q < right_q;

	always_comb begin
		ram.we    = 1'b0;
		ram.waddr = clr_q;
		ram.wdata = '0;
		ram.raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram.we = 1'b1;
			end
			S_WLEAF: begin
				ram.we    = 1'b1;
				ram.waddr = node_q;
				ram.wdata = cur_q;
				ram.raddr = node_q ^ rmt_pkg::node_t'(1);
			end
			S_WUP: begin
				ram.we    = 1'b1;
				ram.waddr = parent;
				ram.wdata = up_val;
				ram.raddr = parent ^ rmt_pkg::node_t'(1);
			end
			S_QL: begin
				ram.raddr = left_q[rmt_pkg::NODE_BITS-1:0];
			end
			S_QR: begin
				ram.raddr = right_m1[rmt_pkg::NODE_BITS-1:0];
			end
			S_IDLE, S_OVR, S_DONE: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			left_q  <= '0;
			right_q <= '0;
			node_q  <= '0;
			cur_q   <= '0;
			best_q  <= '0;
			pend_q  <= 1'b0;
			phase_q <= 1'b0;
			rmax_q  <= '0;
			ovr_q   <= '0;
			bad_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + rmt_pkg::node_t'(1);
					if (clr_q == rmt_pkg::node_t'(rmt_pkg::DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (ctl.start) begin
						bad_q  <= 1'b0;
						rmax_q <= '0;
						if (!item.action) begin
							if (pos_ok) begin
								node_q  <= leaf;
								cur_q   <= rmt_pkg::value_t'(item.value);
								state_q <= S_WLEAF;
							end else begin
								bad_q   <= 1'b1;
								state_q <= S_OVR;
							end
						end else if (q_empty) begin
							state_q <= S_OVR;
						end else begin
							left_q  <= q_left;
							right_q <= q_right;
							best_q  <= '0;
							pend_q  <= 1'b0;
							phase_q <= 1'b0;
							state_q <= S_QL;
						end
					end
				end
				S_WLEAF: begin
					state_q <= S_WUP;
				end
				S_WUP: begin
					cur_q  <= up_val;
					node_q <= parent;
					if (parent == rmt_pkg::node_t'(1)) begin
						state_q <= S_OVR;
					end
				end
				S_QL: begin
					best_q <= best_next;
					if (walk_go) begin
						pend_q <= left_q[0];
						if (left_q[0]) begin
							left_q <= left_q + rmt_pkg::walk_t'(1);
						end
						state_q <= S_QR;
					end else if (!phase_q) begin
						rmax_q  <= best_next;
						state_q <= S_OVR;
					end else begin
						ovr_q   <= best_next;
						state_q <= S_DONE;
					end
				end
				S_QR: begin
					best_q  <= best_next;
					pend_q  <= right_q[0];
					left_q  <= left_q >> 1;
					right_q <= right_q >> 1;
					state_q <= S_QL;
				end
				S_OVR: begin
					if (size == '0) begin
						ovr_q   <= '0;
						state_q <= S_DONE;
					end else begin
						left_q  <= rmt_pkg::walk_t'(rmt_pkg::LEAVES);
						right_q <= ov_right;
						best_q  <= '0;
						pend_q  <= 1'b0;
						phase_q <= 1'b1;
						state_q <= S_QL;
					end
				end
				S_DONE: begin
					if (ctl.ack) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign sts.ready       = state_q == S_IDLE;
	assign sts.done        = state_q == S_DONE;
	assign sts.range_max   = rmax_q;
	assign sts.overall_max = ovr_q;
	assign sts.bad         = bad_q;

endmodule

### src/range_max_tree.sv
// Range maximum store over 1024 positions with point writes.
// s_* carries requests: s_tuser selects the kind (0 write, 1 range query),
// s_tdata holds position, value, range_low and range_high. Every request
// gives one result on m_*: range_max, overall_max and bad_position.
// cfg_* writes used_size; it is always ready. It must be written only while
// idle, a rule on the user that the block does not enforce. One request is
// in work at a time; s_tready is low from acceptance until its result has
// gone into the output register. The tree sits in one RAM with one read and
// one write port, so the walk reads one node per cycle. A write refreshes
// the tree from leaf to root, a range walk reads two nodes per tree level,
// and every request then walks the used range for overall_max. After that
// the sequencer returns to idle before the next request is taken.
// After reset the RAM is cleared one node a cycle, all 2048 nodes, with
// s_tready low; used_size returns to 1024. A stalled receiver holds the
// result in the output register; one more request is taken meanwhile and
// its result waits in the sequencer until the register frees.
module range_max_tree (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// position[10:0], value[30:11], range_low[41:31], range_high[52:42]
	input  rmt_pkg::in_data_t         s_tdata,
	// action[0]
	input  logic                      s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// range_max[19:0], overall_max[39:20], bad_position[40]
	output rmt_pkg::out_data_t        m_tdata,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  rmt_pkg::size_t            cfg_data
);

	`include "range_max_tree_defines.svh"

	rmt_pkg::size_t    used_q;
	rmt_pkg::size_t    size;
	rmt_pkg::item_t    item;
	rmt_pkg::seq_ctl_t ctl;
	rmt_pkg::seq_sts_t sts;
	rmt_pkg::ram_req_t ram;
	rmt_pkg::value_t   rdata;
	logic              out_free;

	logic              m_tvalid_q;
	rmt_pkg::field_t   rmax_q;
	rmt_pkg::field_t   ovr_q;
	logic              bad_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= rmt_pkg::size_t'(rmt_pkg::SIZE_RESET);
		end else if (cfg_valid) begin
			used_q <= cfg_data;
		end
	end

	assign size = rmt_pkg::eff_size(used_q);

	assign item.action     = s_tuser;
	assign item.position   = s_tdata[10:0];
	assign item.value      = s_tdata[30:11];
	assign item.range_low  = s_tdata[41:31];
	assign item.range_high = s_tdata[52:42];

	assign s_tready  = sts.ready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign ctl.start = s_tvalid && sts.ready;
	assign ctl.ack   = sts.done && out_free;

	rmt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.size   (size),
		.ctl    (ctl),
		.item   (item),
		.sts    (sts),
		.ram    (ram),
		.rdata  (rdata)
	);

	rmt_ram #(
		.WIDTH (rmt_pkg::VALUE_BITS),
		.DEPTH (rmt_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram.we),
		.waddr (ram.waddr),
		.wdata (ram.wdata),
		.raddr (ram.raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			rmax_q     <= '0;
			ovr_q      <= '0;
			bad_q      <= 1'b0;
		end else if (ctl.ack) begin
			m_tvalid_q <= 1'b1;
			rmax_q     <= rmt_pkg::field_t'(sts.range_max);
			ovr_q      <= rmt_pkg::field_t'(sts.overall_max);
			bad_q      <= sts.bad;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = rmt_pkg::out_data_t'({bad_q, ovr_q, rmax_q});

	`RMT_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "ready after request")
	`RMT_ASSERT_NEXT(a_result_held, sts.done && !out_free, sts.done, "result lost on stall")
	`RMT_ASSERT_IMPL(a_bad_no_max, m_tvalid_q && bad_q, rmax_q == '0, "bad write with range max")
	`RMT_ASSERT_IMPL(a_range_le_all, m_tvalid_q, rmax_q <= ovr_q, "range max above overall max")

endmodule
